### design/mva_pkg.sv
// Package for the MIDI voice allocator: sizes, op and controller codes,
// decode kinds and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package mva_pkg;

  localparam int NumVoices = 16;
  // Voices actually scannable: limited by the pool and by the 4-bit voice field
  localparam int ActiveMax = (NumVoices < 16) ? NumVoices : 16;

  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_CTRL     = 3'd2;
  localparam logic [2:0] OP_ALL_OFF  = 3'd3;
  localparam logic [2:0] OP_FINISHED = 3'd4;

  localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
  localparam logic [4:0] MaxChannel       = 5'd16;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FINISH,
    KIND_NOTE_ON,
    KIND_RELEASE
  } kind_e;

  typedef enum logic [1:0] {
    MATCH_NOTE,
    MATCH_CHAN,
    MATCH_ALL
  } match_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_REL,
    ST_SCAN_ON,
    ST_FLUSH,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic finish;
    logic scan_rel;
    logic scan_on;
    logic flush;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

### design/mva_ctrl.sv
// Controller FSM of the MIDI voice allocator: sequences accept, voice scan,
// final flush and note-on commit. Depends on mva_pkg.
`default_nettype none

module mva_ctrl import mva_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (sts_i.kind)
            KIND_FINISH:  cmd_o.finish = 1'b1;
            KIND_NOTE_ON: state_d = ST_SCAN_ON;
            KIND_RELEASE: state_d = ST_SCAN_REL;
            default: ;
          endcase
        end
      end
      ST_SCAN_REL: begin
        cmd_o.scan_rel = 1'b1;
        if (sts_i.scan_last) state_d = ST_FLUSH;
      end
      ST_SCAN_ON: begin
        cmd_o.scan_on = 1'b1;
        if (sts_i.scan_last) state_d = ST_COMMIT;
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/mva_dpath.sv
// Datapath of the MIDI voice allocator: voice table, age counter, config
// register, scan trackers and result register. Depends on mva_pkg.
`default_nettype none

module mva_dpath import mva_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  output dp_sts_t         sts_o,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire logic [2:0] op_i,
  input  wire logic [4:0] channel_i,
  input  wire logic [6:0] note_i,
  input  wire logic [6:0] velocity_i,
  input  wire logic [6:0] controller_i,
  input  wire logic [3:0] finished_voice_i,
  output logic            result_valid_o,
  output logic [3:0]      voice_o,
  output logic            action_o,
  output logic [6:0]      out_note_o,
  output logic [6:0]      out_velocity_o,
  output logic [4:0]      out_channel_o,
  output logic            stolen_o,
  output logic            last_o
);

  logic        sounding_q [NumVoices];
  logic        held_q     [NumVoices];
  logic [6:0]  note_q     [NumVoices];
  logic [4:0]  chan_q     [NumVoices];
  logic [31:0] age_q      [NumVoices];
  logic [31:0] age_cnt_q;
  logic [4:0]  voice_count_q;

  // latched word
  match_e      mode_q;
  logic [4:0]  in_ch_q;
  logic [6:0]  in_note_q;
  logic [6:0]  in_vel_q;

  // scan state
  logic [3:0]  idx_q;
  logic        silent_found_q, free_found_q;
  logic [3:0]  silent_idx_q, free_idx_q, best_idx_q;
  logic [31:0] best_age_q;
  logic        pend_v_q;
  logic [3:0]  pend_voice_q;
  logic [6:0]  pend_note_q;
  logic [4:0]  pend_chan_q;

  // result register
  logic        out_v_q;
  logic [3:0]  out_voice_q;
  logic        out_act_q;
  logic [6:0]  out_note_q;
  logic [6:0]  out_vel_q;
  logic [4:0]  out_chan_q;
  logic        out_stolen_q;
  logic        out_last_q;

  logic [4:0]  n_eff;
  kind_e       kind;
  match_e      mode;
  logic        cur_match;
  logic [3:0]  pick_idx;
  logic        fin_ok;

  assign n_eff  = (voice_count_q > 5'(ActiveMax)) ? 5'(ActiveMax) : voice_count_q;
  assign fin_ok = ({1'b0, finished_voice_i} < 5'(NumVoices));

  always_comb begin
    kind = KIND_NONE;
    mode = MATCH_ALL;
    unique case (op_i)
      OP_NOTE_ON: begin
        if (channel_i != 5'd0 && channel_i <= MaxChannel) begin
          if (velocity_i == 7'd0) begin
            kind = KIND_RELEASE;
            mode = MATCH_NOTE;
          end else begin
            kind = KIND_NOTE_ON;
          end
        end
      end
      OP_NOTE_OFF: begin
        kind = KIND_RELEASE;
        mode = MATCH_NOTE;
      end
      OP_CTRL: begin
        if (controller_i == CC_ALL_SOUND_OFF || controller_i == CC_ALL_NOTES_OFF) begin
          kind = KIND_RELEASE;
          mode = MATCH_CHAN;
        end
      end
      OP_ALL_OFF: kind = KIND_RELEASE;
      OP_FINISHED: kind = KIND_FINISH;
      default: ;
    endcase
    // nothing to scan with no voices in use
    if ((kind == KIND_RELEASE || kind == KIND_NOTE_ON) && n_eff == 5'd0) kind = KIND_NONE;
  end

  always_comb begin
    unique case (mode_q)
      MATCH_NOTE: cur_match = held_q[idx_q] && note_q[idx_q] == in_note_q &&
                              chan_q[idx_q] == in_ch_q;
      MATCH_CHAN: cur_match = (chan_q[idx_q] == in_ch_q);
      default:    cur_match = 1'b1;
    endcase
  end

  assign pick_idx = silent_found_q ? silent_idx_q :
                    free_found_q   ? free_idx_q   : best_idx_q;

  assign sts_o.kind      = kind;
  assign sts_o.scan_last = ({1'b0, idx_q} == n_eff - 5'd1);

  // Voice table, counters and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumVoices; i++) begin
        sounding_q[i] <= 1'b0;
        held_q[i]     <= 1'b0;
        note_q[i]     <= '0;
        chan_q[i]     <= '0;
        age_q[i]      <= '0;
      end
      age_cnt_q      <= '0;
      voice_count_q  <= 5'd16;
      pend_v_q       <= 1'b0;
      silent_found_q <= 1'b0;
      free_found_q   <= 1'b0;
      idx_q          <= '0;
      out_v_q        <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      if (cfg_we_i) voice_count_q <= cfg_data_i;
      if (cmd_i.load) begin
        idx_q          <= '0;
        pend_v_q       <= 1'b0;
        silent_found_q <= 1'b0;
        free_found_q   <= 1'b0;
      end
      if (cmd_i.finish && fin_ok) sounding_q[finished_voice_i] <= 1'b0;
      if (cmd_i.scan_rel) begin
        idx_q <= idx_q + 4'd1;
        if (cur_match) begin
          held_q[idx_q] <= 1'b0;
          pend_v_q      <= 1'b1;
          if (pend_v_q) out_v_q <= 1'b1;
        end
      end
      if (cmd_i.scan_on) begin
        idx_q <= idx_q + 4'd1;
        if (!sounding_q[idx_q]) silent_found_q <= 1'b1;
        if (!held_q[idx_q])     free_found_q   <= 1'b1;
      end
      if (cmd_i.flush && pend_v_q) out_v_q <= 1'b1;
      if (cmd_i.commit) begin
        out_v_q              <= 1'b1;
        age_cnt_q            <= age_cnt_q + 32'd1;
        sounding_q[pick_idx] <= 1'b1;
        held_q[pick_idx]     <= 1'b1;
        note_q[pick_idx]     <= in_note_q;
        chan_q[pick_idx]     <= in_ch_q;
        age_q[pick_idx]      <= age_cnt_q + 32'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode;
      in_ch_q    <= channel_i;
      in_note_q  <= note_i;
      in_vel_q   <= velocity_i;
      best_age_q <= '1;
      best_idx_q <= '0;
    end
    if (cmd_i.scan_on) begin
      if (!sounding_q[idx_q] && !silent_found_q) silent_idx_q <= idx_q;
      if (!held_q[idx_q] && !free_found_q)       free_idx_q   <= idx_q;
      if (age_q[idx_q] < best_age_q) begin
        best_age_q <= age_q[idx_q];
        best_idx_q <= idx_q;
      end
    end
    if (cmd_i.scan_rel && cur_match) begin
      pend_voice_q <= idx_q;
      pend_note_q  <= note_q[idx_q];
      pend_chan_q  <= chan_q[idx_q];
    end
    // a pending release goes out when the next match or the scan end shows up
    if ((cmd_i.scan_rel && cur_match) || cmd_i.flush) begin
      out_voice_q  <= pend_voice_q;
      out_act_q    <= ACT_RELEASE;
      out_note_q   <= pend_note_q;
      out_vel_q    <= 7'd0;
      out_chan_q   <= pend_chan_q;
      out_stolen_q <= 1'b0;
      out_last_q   <= cmd_i.flush;
    end
    if (cmd_i.commit) begin
      out_voice_q  <= pick_idx;
      out_act_q    <= ACT_START;
      out_note_q   <= in_note_q;
      out_vel_q    <= in_vel_q;
      out_chan_q   <= in_ch_q;
      out_stolen_q <= sounding_q[pick_idx];
      out_last_q   <= 1'b1;
    end
  end

  assign result_valid_o = out_v_q;
  assign voice_o        = out_voice_q;
  assign action_o       = out_act_q;
  assign out_note_o     = out_note_q;
  assign out_velocity_o = out_vel_q;
  assign out_channel_o  = out_chan_q;
  assign stolen_o       = out_stolen_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

### design/midi_voice_allocator.sv
// Top level of the MIDI voice allocator: controller FSM plus datapath.
// Depends on mva_pkg, mva_ctrl and mva_dpath.
//
// Input: an event word (op, channel, note, velocity, controller,
//   finished_voice) is taken at a rising edge with start_i high and busy_o low.
// Config: cfg_we_i writes cfg_data_i into voice_count; write only while idle.
// Results: result_valid_o strobes one cycle per result word; the receiver
//   cannot stall, so each strobed word is taken at the end of that cycle.
//   last_o marks the final word of an event.
// Sequencing (n = voice_count limited to 16):
//   Voice finished, ignored events and unknown ops: done at the accept edge,
//   busy_o stays low, no result.
//   Note-on and release events (note-off, CC 120/123, all-notes-off): a scan
//   of the n voices, one entry per cycle, then a commit or flush step; the
//   start word, or the final release word, is registered by that step. Release
//   words trail their voice by one match. busy_o stays high through the scan
//   and the commit or flush step; the next event is taken once it drops.
// Reset: all voices silent and released with note/channel/age zero, age
//   counter zero, voice_count 16.
`default_nettype none

module midi_voice_allocator import mva_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire logic [2:0] op_i,
  input  wire logic [4:0] channel_i,
  input  wire logic [6:0] note_i,
  input  wire logic [6:0] velocity_i,
  input  wire logic [6:0] controller_i,
  input  wire logic [3:0] finished_voice_i,
  output logic            result_valid_o,
  output logic [3:0]      voice_o,
  output logic            action_o,
  output logic [6:0]      out_note_o,
  output logic [6:0]      out_velocity_o,
  output logic [4:0]      out_channel_o,
  output logic            stolen_o,
  output logic            last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mva_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  mva_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .channel_i        (channel_i),
    .note_i           (note_i),
    .velocity_i       (velocity_i),
    .controller_i     (controller_i),
    .finished_voice_i (finished_voice_i),
    .result_valid_o   (result_valid_o),
    .voice_o          (voice_o),
    .action_o         (action_o),
    .out_note_o       (out_note_o),
    .out_velocity_o   (out_velocity_o),
    .out_channel_o    (out_channel_o),
    .stolen_o         (stolen_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
